// File: rtl/assert_macros.svh
// Assertion macros used by the RTL datapath (ewct_dp).
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ewct_pkg.sv
// Package for the capacitated tree block: sizes, codes, command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ewct_pkg;
  localparam int MAX_V = 32;
  localparam int COST_BITS = 16;
  localparam int VW = $clog2(MAX_V);
  localparam int CW = $clog2(MAX_V + 1);
  localparam int DEM_W = 21;
  localparam int LOAD_W = 16;
  localparam int FW = 5;

  typedef enum logic [1:0] {
    REQ_COST = 2'd0, REQ_DEMAND = 2'd1, REQ_START = 2'd2, REQ_NONE = 2'd3
  } req_t;

  localparam logic [1:0] CFG_ROOT  = 2'd0;
  localparam logic [1:0] CFG_CAP   = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_START, DP_INIT, DP_ILOAD, DP_JSCAN, DP_IEVAL, DP_PCLR,
    DP_M1, DP_M2, DP_OSTART, DP_OEDGE, DP_OVERT, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [VW-1:0]   i;
    logic [VW-1:0]   j;
  } dp_cmd_t;

  typedef struct packed {
    logic [CW-1:0] n;
    logic [VW-1:0] root;
    logic          found;
    logic [CW-1:0] mcount;
    logic          out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_IDRAIN, S_PSTART, S_ISEL, S_ILOAD, S_JSCAN, S_JDRAIN,
    S_IEVAL, S_MCHK, S_M1, S_M2, S_OSTART, S_OEDGE, S_OVERT, S_EMIT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/ewct_ctrl.sv
// Sequencer for input requests, setup, the merge search, tree orientation and result emission.
// Depends on ewct_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module ewct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire ewct_pkg::dp_stat_t stat,
  output ewct_pkg::dp_cmd_t       cmd
);
  ewct_pkg::state_t            state, state_next;
  logic [ewct_pkg::CW-1:0]     cnt, cnt_next;
  logic [ewct_pkg::CW-1:0]     jc, jc_next;
  logic [ewct_pkg::CW-1:0]     pass, pass_next;
  logic [ewct_pkg::VW-1:0]     i_r, i_r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ewct_pkg::S_IDLE;
      cnt   <= '0;
      jc    <= '0;
      pass  <= '0;
      i_r   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      jc    <= jc_next;
      pass  <= pass_next;
      i_r   <= i_r_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    jc_next    = jc;
    pass_next  = pass;
    i_r_next   = i_r;
    cmd.op     = ewct_pkg::DP_NONE;
    cmd.i      = i_r;
    cmd.j      = cnt[ewct_pkg::VW-1:0];
    in_stall   = 1'b1;
    unique case (state)
      ewct_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (req_type == ewct_pkg::REQ_START) begin
            cmd.op     = ewct_pkg::DP_START;
            cnt_next   = '0;
            state_next = ewct_pkg::S_INIT;
          end else if (req_type == ewct_pkg::REQ_COST || req_type == ewct_pkg::REQ_DEMAND) begin
            cmd.op = ewct_pkg::DP_LOAD;
          end
        end
      end
      ewct_pkg::S_INIT: begin
        cmd.op   = ewct_pkg::DP_INIT;
        cnt_next = cnt + 1'b1;
        if (cnt == ewct_pkg::CW'(ewct_pkg::MAX_V - 1)) state_next = ewct_pkg::S_IDRAIN;
      end
      ewct_pkg::S_IDRAIN: state_next = ewct_pkg::S_PSTART;
      ewct_pkg::S_PSTART: begin
        cmd.op     = ewct_pkg::DP_PCLR;
        cnt_next   = '0;
        state_next = ewct_pkg::S_ISEL;
      end
      ewct_pkg::S_ISEL: begin
        if (cnt == stat.n) begin
          state_next = ewct_pkg::S_MCHK;
        end else if (cnt[ewct_pkg::VW-1:0] == stat.root) begin
          cnt_next = cnt + 1'b1;
        end else begin
          i_r_next   = cnt[ewct_pkg::VW-1:0];
          state_next = ewct_pkg::S_ILOAD;
        end
      end
      ewct_pkg::S_ILOAD: begin
        cmd.op     = ewct_pkg::DP_ILOAD;
        jc_next    = '0;
        state_next = ewct_pkg::S_JSCAN;
      end
      ewct_pkg::S_JSCAN: begin
        cmd.op  = ewct_pkg::DP_JSCAN;
        cmd.j   = jc[ewct_pkg::VW-1:0];
        jc_next = jc + 1'b1;
        if (jc == stat.n - 1'b1) state_next = ewct_pkg::S_JDRAIN;
      end
      ewct_pkg::S_JDRAIN: state_next = ewct_pkg::S_IEVAL;
      ewct_pkg::S_IEVAL: begin
        cmd.op     = ewct_pkg::DP_IEVAL;
        cnt_next   = cnt + 1'b1;
        state_next = ewct_pkg::S_ISEL;
      end
      ewct_pkg::S_MCHK: begin
        if (!stat.found || stat.mcount >= ewct_pkg::CW'(ewct_pkg::MAX_V))
          state_next = ewct_pkg::S_OSTART;
        else
          state_next = ewct_pkg::S_M1;
      end
      ewct_pkg::S_M1: begin
        cmd.op     = ewct_pkg::DP_M1;
        state_next = ewct_pkg::S_M2;
      end
      ewct_pkg::S_M2: begin
        cmd.op     = ewct_pkg::DP_M2;
        state_next = ewct_pkg::S_PSTART;
      end
      ewct_pkg::S_OSTART: begin
        cmd.op     = ewct_pkg::DP_OSTART;
        cnt_next   = '0;
        pass_next  = '0;
        state_next = ewct_pkg::S_OEDGE;
      end
      ewct_pkg::S_OEDGE: begin
        if (cnt == stat.mcount) begin
          cnt_next   = '0;
          state_next = ewct_pkg::S_OVERT;
        end else begin
          cmd.op   = ewct_pkg::DP_OEDGE;
          cnt_next = cnt + 1'b1;
        end
      end
      ewct_pkg::S_OVERT: begin
        if (cnt == stat.n) begin
          cnt_next = '0;
          if (pass == stat.n - 1'b1) begin
            state_next = ewct_pkg::S_EMIT;
          end else begin
            pass_next  = pass + 1'b1;
            state_next = ewct_pkg::S_OEDGE;
          end
        end else begin
          cmd.op   = ewct_pkg::DP_OVERT;
          cnt_next = cnt + 1'b1;
        end
      end
      ewct_pkg::S_EMIT: begin
        if (cnt == stat.n) begin
          state_next = ewct_pkg::S_IDLE;
        end else if (stat.out_free) begin
          cmd.op   = ewct_pkg::DP_EMIT;
          cnt_next = cnt + 1'b1;
        end
      end
      default: state_next = ewct_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/ewct_dp.sv
// Datapath: cost memory, component state, merge search, tree orientation, output register.
// Depends on ewct_pkg and assert_macros.svh; commanded by ewct_ctrl.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ewct_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ewct_pkg::dp_cmd_t             cmd,
  output ewct_pkg::dp_stat_t                 stat,
  input  wire logic [1:0]                    req_type,
  input  wire logic [ewct_pkg::FW-1:0]       row_vertex,
  input  wire logic [ewct_pkg::FW-1:0]       col_vertex,
  input  wire logic [ewct_pkg::LOAD_W-1:0]   load_value,
  input  wire logic                          cfg_valid,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [ewct_pkg::DEM_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ewct_pkg::FW-1:0]            vertex,
  output logic [ewct_pkg::FW-1:0]            parent,
  output logic                               last
);
  localparam int VW = ewct_pkg::VW;
  localparam int CW = ewct_pkg::CW;
  localparam int NV = ewct_pkg::MAX_V;
  localparam int CB = ewct_pkg::COST_BITS;
  localparam int DW = ewct_pkg::DEM_W;

  logic [4:0]      root_cfg;
  logic [DW-1:0]   cap_cfg;
  logic [5:0]      cnt_cfg;
  logic [CW-1:0]   n_r, n_calc;
  logic [VW-1:0]   root_r, root_calc;

  logic [CB-1:0]   cost_mem [NV*NV];
  logic [CB-1:0]   cost_q;
  logic [2*VW-1:0] cost_addr;
  logic            cost_we;

  logic [ewct_pkg::LOAD_W-1:0] vdem [NV];
  logic [VW-1:0]   link [NV];
  logic [DW-1:0]   vd [NV];
  logic [CB-1:0]   gc [NV];
  logic [VW-1:0]   gv [NV];
  logic [VW-1:0]   edge_a [NV];
  logic [VW-1:0]   edge_b [NV];
  logic [VW-1:0]   tpar [NV];
  logic [NV-1:0]   seen;
  logic [CW-1:0]   mcount;

  logic [VW-1:0]   rd_addr, rd_link, rd_gv;
  logic [DW-1:0]   rd_vd;
  logic [CB-1:0]   rd_gc;

  logic            init_vld, init_use;
  logic [VW-1:0]   init_v;
  logic            sc_vld, sc_ok, sc_take;
  logic [VW-1:0]   sc_j;
  logic [VW-1:0]   ci_r;
  logic [DW-1:0]   di_r;
  logic [CB-1:0]   gi_r;
  logic            have;
  logic [CB-1:0]   pc;
  logic [VW-1:0]   pj;
  logic            found;
  logic [CB-1:0]   bsav, bcost, sav;
  logic [VW-1:0]   bi, bj;
  logic            ev_take;
  logic [VW-1:0]   mci, mgv, sel_gv;
  logic [CB-1:0]   mgc, sel_gc;
  logic [DW-1:0]   md, nd;
  logic [VW-1:0]   ea, eb;

  always_comb begin
    if (int'(cnt_cfg) < 2) n_calc = CW'(2);
    else if (int'(cnt_cfg) > NV) n_calc = CW'(NV);
    else n_calc = CW'(cnt_cfg);
    if (CW'(root_cfg) >= n_calc) root_calc = '0;
    else root_calc = root_cfg[VW-1:0];
  end

  always_comb begin
    unique case (cmd.op)
      ewct_pkg::DP_ILOAD: rd_addr = cmd.i;
      ewct_pkg::DP_M1:    rd_addr = bi;
      ewct_pkg::DP_M2:    rd_addr = bj;
      default:            rd_addr = cmd.j;
    endcase
    rd_link = link[rd_addr];
    rd_vd   = vd[rd_addr];
    rd_gc   = gc[rd_addr];
    rd_gv   = gv[rd_addr];
  end

  always_comb begin
    unique case (cmd.op)
      ewct_pkg::DP_INIT: cost_addr = {root_r, cmd.j};
      ewct_pkg::DP_LOAD: cost_addr = {row_vertex[VW-1:0], col_vertex[VW-1:0]};
      default:           cost_addr = {cmd.i, cmd.j};
    endcase
    cost_we = (cmd.op == ewct_pkg::DP_LOAD) && (req_type == ewct_pkg::REQ_COST);
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_addr] <= load_value[CB-1:0];
    cost_q <= cost_mem[cost_addr];
  end

  assign sc_take = sc_vld && sc_ok && (!have || cost_q < pc);
  assign sav     = gi_r - pc;
  assign ev_take = have && (gi_r > pc) &&
                   (!found || sav > bsav || (sav == bsav && pc < bcost));
  assign nd      = md + rd_vd;
  assign sel_gc  = (mgc <= rd_gc) ? mgc : rd_gc;
  assign sel_gv  = (mgc <= rd_gc) ? mgv : rd_gv;
  assign ea      = edge_a[cmd.j];
  assign eb      = edge_b[cmd.j];

  always_ff @(posedge clk) begin
    if (rst) begin
      root_cfg  <= '0;
      cap_cfg   <= '1;
      cnt_cfg   <= 6'(NV);
      out_valid <= 1'b0;
      found     <= 1'b0;
      have      <= 1'b0;
      sc_vld    <= 1'b0;
      init_vld  <= 1'b0;
      mcount    <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ewct_pkg::CFG_ROOT) root_cfg <= cfg_data[4:0];
        else if (cfg_index == ewct_pkg::CFG_CAP) cap_cfg <= cfg_data;
        else if (cfg_index == ewct_pkg::CFG_COUNT) cnt_cfg <= cfg_data[5:0];
      end
      sc_vld   <= (cmd.op == ewct_pkg::DP_JSCAN);
      init_vld <= (cmd.op == ewct_pkg::DP_INIT);
      if (cmd.op == ewct_pkg::DP_ILOAD) have <= 1'b0;
      else if (sc_take) have <= 1'b1;
      if (cmd.op == ewct_pkg::DP_PCLR) found <= 1'b0;
      else if (cmd.op == ewct_pkg::DP_IEVAL && ev_take) found <= 1'b1;
      if (cmd.op == ewct_pkg::DP_START) mcount <= '0;
      else if (cmd.op == ewct_pkg::DP_M2) mcount <= mcount + 1'b1;
      if (cmd.op == ewct_pkg::DP_EMIT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (init_vld) gc[init_v] <= init_use ? cost_q : '0;
    if (sc_take) begin
      pc <= cost_q;
      pj <= sc_j;
    end
    unique case (cmd.op)
      ewct_pkg::DP_LOAD: begin
        if (req_type == ewct_pkg::REQ_DEMAND) vdem[row_vertex[VW-1:0]] <= load_value;
      end
      ewct_pkg::DP_START: begin
        n_r    <= n_calc;
        root_r <= root_calc;
      end
      ewct_pkg::DP_INIT: begin
        link[cmd.j] <= cmd.j;
        gv[cmd.j]   <= cmd.j;
        init_v      <= cmd.j;
        init_use    <= (CW'(cmd.j) < n_r) && (cmd.j != root_r);
        vd[cmd.j]   <= ((CW'(cmd.j) < n_r) && (cmd.j != root_r)) ? DW'(vdem[cmd.j]) : '0;
      end
      ewct_pkg::DP_ILOAD: begin
        ci_r <= rd_link;
        di_r <= rd_vd;
        gi_r <= rd_gc;
      end
      ewct_pkg::DP_JSCAN: begin
        sc_j  <= cmd.j;
        sc_ok <= (cmd.j != root_r) && (cmd.j != cmd.i) && (rd_link != ci_r) &&
                 ({1'b0, di_r} + {1'b0, rd_vd} <= {1'b0, cap_cfg});
      end
      ewct_pkg::DP_IEVAL: begin
        if (ev_take) begin
          bsav  <= sav;
          bcost <= pc;
          bi    <= cmd.i;
          bj    <= pj;
        end
      end
      ewct_pkg::DP_M1: begin
        mci <= rd_link;
        mgc <= rd_gc;
        mgv <= rd_gv;
        md  <= rd_vd;
      end
      ewct_pkg::DP_M2: begin
        for (int v = 0; v < NV; v++) begin
          if (link[v] == mci || link[v] == rd_link) begin
            vd[v] <= nd;
            gc[v] <= sel_gc;
            gv[v] <= sel_gv;
          end
          if (link[v] == mci) link[v] <= rd_link;
        end
        edge_a[mcount[VW-1:0]] <= bi;
        edge_b[mcount[VW-1:0]] <= bj;
      end
      ewct_pkg::DP_OSTART: begin
        seen <= NV'(1) << root_r;
        for (int v = 0; v < NV; v++) tpar[v] <= root_r;
      end
      ewct_pkg::DP_OEDGE: begin
        if (seen[ea] && !seen[eb]) begin
          tpar[eb] <= ea;
          seen[eb] <= 1'b1;
        end else if (seen[eb] && !seen[ea]) begin
          tpar[ea] <= eb;
          seen[ea] <= 1'b1;
        end
      end
      ewct_pkg::DP_OVERT: begin
        if (cmd.j != root_r && rd_link == cmd.j && !seen[rd_gv]) begin
          tpar[rd_gv] <= root_r;
          seen[rd_gv] <= 1'b1;
        end
      end
      ewct_pkg::DP_EMIT: begin
        vertex <= ewct_pkg::FW'(cmd.j);
        parent <= ewct_pkg::FW'(tpar[cmd.j]);
        last   <= (CW'(cmd.j) + 1'b1 == n_r);
      end
      default: ;
    endcase
  end

  assign stat.n        = n_r;
  assign stat.root     = root_r;
  assign stat.found    = found;
  assign stat.mcount   = mcount;
  assign stat.out_free = !out_valid || !out_stall;

  `ASSERT_ALWAYS(a_mcount_bound, clk, rst, mcount <= CW'(NV))
  `ASSERT_IMPLIES(a_found_saving, clk, rst, found, bsav != '0)
  `ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.op == ewct_pkg::DP_EMIT, !(out_valid && out_stall))
endmodule
`default_nettype wire

// File: rtl/esau_williams_capacitated_tree.sv
// Esau-Williams capacitated tree: a load is written while idle; a start runs the setup,
// then up to n search passes (one cost read per pair), then the tree orientation,
// then n results at one per unstalled cycle.
// Input is stalled from the start until the last result is issued; one start at a time.
// Reset (rst, synchronous): registers return to root 0, full capacity, 32 vertices; idle.
`timescale 1ns / 1ps
`default_nettype none
module esau_williams_capacitated_tree (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [4:0]  row_vertex,
  input  wire logic [4:0]  col_vertex,
  input  wire logic [15:0] load_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       vertex,
  output logic [4:0]       parent,
  output logic             last
);
  ewct_pkg::dp_cmd_t  cmd;
  ewct_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ewct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  ewct_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .row_vertex (row_vertex),
    .col_vertex (col_vertex),
    .load_value (load_value),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .vertex     (vertex),
    .parent     (parent),
    .last       (last)
  );
endmodule
`default_nettype wire
